[hw/rtl/phr_pkg.sv]
// Package for the pressure history recorder: field widths, codes, payload
// structs and default parameter values. No dependencies.
`timescale 1ns / 1ps

package phr_pkg;

   // Default sizing, handed down by the top level
   localparam int DEF_HISTORY_DEPTH  = 1024;
   localparam int DEF_WARMUP_SAMPLES = 5;

   // Field widths
   localparam int FUNC_W   = 2;
   localparam int PRESS_W  = 15;
   localparam int INDEX_W  = 10;
   localparam int SMOOTH_W = 23;
   localparam int ALPHA_W  = 16;
   localparam int SKIP_W   = 3;
   localparam int COUNT_W  = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Read index of the newest history entry
   localparam logic [INDEX_W-1:0] READ_NEWEST = 10'd1023;

   // Reset values
   localparam logic [PRESS_W-1:0] LOW_LIMIT_RST  = 15'd7000;
   localparam logic [PRESS_W-1:0] HIGH_LIMIT_RST = 15'd20000;
   localparam logic [ALPHA_W-1:0] ALPHA_RST      = 16'd655;
   localparam logic [SKIP_W-1:0]  SKIP_COUNT_RST = 3'd2;
   localparam logic [PRESS_W-1:0] MIN_START      = 15'd12000;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_SAMPLE  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_OTHER   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd3;

   // Register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_LIMIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_COUNT = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [PRESS_W-1:0] sample;
      logic [INDEX_W-1:0] index;
   } phr_req_type;

   typedef struct packed {
      logic [PRESS_W-1:0]  current_pressure;
      logic                current_valid;
      logic                running;
      logic [COUNT_W-1:0]  filled_count;
      logic [PRESS_W-1:0]  window_max;
      logic [PRESS_W-1:0]  overall_max;
      logic [PRESS_W-1:0]  overall_min;
      logic [SMOOTH_W-1:0] newest_smoothed;
      logic [PRESS_W-1:0]  read_raw;
      logic [SMOOTH_W-1:0] read_smoothed;
      logic                read_valid;
   } phr_rsp_type;

   typedef struct packed {
      logic [PRESS_W-1:0] low_limit;
      logic [PRESS_W-1:0] high_limit;
      logic [ALPHA_W-1:0] alpha;
      logic [SKIP_W-1:0]  skip_count;
   } phr_cfg_type;

   // Work kind decided by the front end
   typedef enum logic [1:0] {
      KIND_NOP     = 2'd0,
      KIND_SAMPLE  = 2'd1,
      KIND_TIMEOUT = 2'd2,
      KIND_READ    = 2'd3
   } phr_kind_type;

   typedef struct packed {
      phr_kind_type       kind;
      logic [PRESS_W-1:0] sample;
      logic [INDEX_W-1:0] age;
   } phr_item_type;

endpackage

[hw/rtl/phr_front.sv]
// Front end: takes request transactions, classifies them and holds them in
// a two-entry queue for the back end. Depends on phr_pkg.
`timescale 1ns / 1ps

module phr_front
   import phr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  phr_req_type  req_data,
   input  phr_cfg_type  cfg,
   output logic         q_valid,
   output phr_item_type q_item,
   input  logic         q_pop
);

   phr_item_type fifo_ff [2];
   logic [0:0]   wr_ptr_ff, wr_ptr_in;
   logic [0:0]   rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   phr_item_type item;
   logic         push;
   logic         in_range;

   assign req_ready = (count_ff != 2'd2);
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = fifo_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;

   // Classify the incoming transaction
   always_comb begin
      in_range    = (req_data.sample > cfg.low_limit) && (req_data.sample < cfg.high_limit);
      item.sample = req_data.sample;
      item.age    = READ_NEWEST - req_data.index;
      case (req_data.func)
         FUNC_SAMPLE:  item.kind = in_range ? KIND_SAMPLE : KIND_NOP;
         FUNC_OTHER:   item.kind = KIND_NOP;
         FUNC_TIMEOUT: item.kind = KIND_TIMEOUT;
         FUNC_READ:    item.kind = KIND_READ;
         default:      item.kind = KIND_NOP;
      endcase
   end

   // Advance queue pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

[hw/rtl/phr_back.sv]
// Back end: runs one queued transaction at a time against the history rings,
// warmup average, smoothing and extremes, then registers the response.
// Depends on phr_pkg.
`timescale 1ns / 1ps

module phr_back
   import phr_pkg::*;
#(
   parameter int HISTORY_DEPTH  = DEF_HISTORY_DEPTH,
   parameter int WARMUP_SAMPLES = DEF_WARMUP_SAMPLES
) (
   input  logic         clock,
   input  logic         reset,
   input  phr_cfg_type  cfg,
   input  logic         q_valid,
   input  phr_item_type q_item,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output phr_rsp_type  rsp_data
);

   localparam int PTR_W    = $clog2(HISTORY_DEPTH);
   localparam int HC_W     = $clog2(HISTORY_DEPTH + 1);
   localparam int CW       = PTR_W + INDEX_W + 1;
   localparam int SUM_W    = 18;
   localparam int DIV_SHIFT = 21;
   localparam int DIV_MUL_W = 22;
   localparam logic [DIV_MUL_W-1:0] DIV_MUL =
      DIV_MUL_W'((2**DIV_SHIFT + WARMUP_SAMPLES - 1) / WARMUP_SAMPLES);
   localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(HISTORY_DEPTH - 1);
   localparam logic [HC_W-1:0]  FULL_COUNT = HC_W'(HISTORY_DEPTH);

   typedef enum logic [7:0] {
      S_IDLE      = 8'b00000001,
      S_EXEC      = 8'b00000010,
      S_MEAN      = 8'b00000100,
      S_SUM       = 8'b00001000,
      S_SCAN      = 8'b00010000,
      S_SCAN_LAST = 8'b00100000,
      S_DONE      = 8'b01000000,
      S_SPARE     = 8'b10000000
   } phr_state_type;

   phr_state_type state_ff, state_in;
   phr_item_type  item_ff, item_in;

   logic [PTR_W-1:0]    wp_ff, wp_in;
   logic [HC_W-1:0]     held_ff, held_in;
   logic [2:0]          warm_cnt_ff, warm_cnt_in;
   logic [SUM_W-1:0]    warm_sum_ff, warm_sum_in;
   logic [SKIP_W-1:0]   skip_left_ff, skip_left_in;
   logic [PRESS_W-1:0]  shown_ff, shown_in;
   logic                shown_valid_ff, shown_valid_in;
   logic                running_ff, running_in;
   logic [PRESS_W-1:0]  mwin_ff, mwin_in;
   logic [PRESS_W-1:0]  max_ff, max_in;
   logic [PRESS_W-1:0]  min_ff, min_in;
   logic [SMOOTH_W-1:0] last_sm_ff, last_sm_in;
   logic [PRESS_W-1:0]  last_raw_ff, last_raw_in;
   logic [38:0]         prod_a_ff, prod_a_in;
   logic [39:0]         prod_b_ff, prod_b_in;
   logic                rd_ok_ff, rd_ok_in;
   logic [PTR_W-1:0]    scan_addr_ff, scan_addr_in;
   logic                scan_pend_ff, scan_pend_in;
   logic [PRESS_W-1:0]  scan_max_ff, scan_max_in;
   logic                rsp_valid_ff, rsp_valid_in;
   phr_rsp_type         rsp_ff, rsp_in;

   // History rings, one write port and one registered read port
   logic [PRESS_W-1:0]  raw_mem    [HISTORY_DEPTH];
   logic [SMOOTH_W-1:0] smooth_mem [HISTORY_DEPTH];
   logic [PRESS_W-1:0]  raw_q_ff;
   logic [SMOOTH_W-1:0] smooth_q_ff;
   logic                mem_we;
   logic                rd_en;
   logic [PTR_W-1:0]    rd_addr;

   logic [PTR_W-1:0]    newest;
   logic [CW-1:0]       newest_c, age_c, slot_c;
   logic [PTR_W-1:0]    slot;
   logic                age_ok;
   logic [HC_W+INDEX_W-1:0] age_ext, held_cmp;
   logic [HC_W+COUNT_W-1:0] held_ext;
   logic [PRESS_W-1:0]  prev_raw;
   logic [SMOOTH_W-1:0] prev_sm;
   logic [16:0]         inv_alpha;
   logic [SUM_W-1:0]    sum_next;
   logic [SUM_W+DIV_MUL_W-1:0] mean_prod;
   logic [40:0]         acc;
   logic [SMOOTH_W-1:0] sm_new;

   assign q_pop     = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Locate the slot for a history read
   always_comb begin
      newest   = (wp_ff == '0) ? LAST_SLOT : wp_ff - 1'b1;
      newest_c = CW'(newest);
      age_c    = CW'(item_ff.age);
      slot_c   = (newest_c >= age_c) ? newest_c - age_c
                                     : newest_c + CW'(HISTORY_DEPTH) - age_c;
      slot     = slot_c[PTR_W-1:0];
      age_ext  = {{HC_W{1'b0}}, item_ff.age};
      held_cmp = {{INDEX_W{1'b0}}, held_ff};
      age_ok   = age_ext < held_cmp;
      held_ext = {{COUNT_W{1'b0}}, held_ff};
   end

   // Smoothing operands and the warmup mean
   always_comb begin
      prev_raw  = (held_ff == '0) ? item_ff.sample : last_raw_ff;
      prev_sm   = (held_ff == '0) ? {item_ff.sample, 8'd0} : last_sm_ff;
      inv_alpha = 17'h10000 - {1'b0, cfg.alpha};
      sum_next  = warm_sum_ff + SUM_W'(item_ff.sample);
      mean_prod = (SUM_W+DIV_MUL_W)'(warm_sum_ff) * (SUM_W+DIV_MUL_W)'(DIV_MUL);
      acc       = 41'(prod_a_ff) + 41'(prod_b_ff) + 41'd32768;
      sm_new    = acc[38:16];
   end

   // Sequence one transaction
   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      wp_in          = wp_ff;
      held_in        = held_ff;
      warm_cnt_in    = warm_cnt_ff;
      warm_sum_in    = warm_sum_ff;
      skip_left_in   = skip_left_ff;
      shown_in       = shown_ff;
      shown_valid_in = shown_valid_ff;
      running_in     = running_ff;
      mwin_in        = mwin_ff;
      max_in         = max_ff;
      min_in         = min_ff;
      last_sm_in     = last_sm_ff;
      last_raw_in    = last_raw_ff;
      prod_a_in      = prod_a_ff;
      prod_b_in      = prod_b_ff;
      rd_ok_in       = rd_ok_ff;
      scan_addr_in   = scan_addr_ff;
      scan_pend_in   = scan_pend_ff;
      scan_max_in    = scan_max_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_in         = rsp_ff;
      mem_we         = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = slot;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               item_in  = q_item;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_DONE;
            case (item_ff.kind)
               KIND_TIMEOUT: shown_valid_in = 1'b0;
               KIND_READ: begin
                  rd_en    = 1'b1;
                  rd_ok_in = age_ok;
               end
               KIND_SAMPLE: begin
                  if (skip_left_ff != '0) begin
                     skip_left_in = skip_left_ff - 1'b1;
                  end else begin
                     shown_in       = item_ff.sample;
                     shown_valid_in = 1'b1;
                     if (warm_cnt_ff < 3'(WARMUP_SAMPLES)) begin
                        warm_sum_in = sum_next;
                        warm_cnt_in = warm_cnt_ff + 1'b1;
                        if (warm_cnt_ff + 1'b1 == 3'(WARMUP_SAMPLES)) begin
                           state_in = S_MEAN;
                        end
                     end else begin
                        running_in = 1'b1;
                        prod_a_in  = 39'(cfg.alpha) * 39'({prev_raw, 8'd0});
                        prod_b_in  = 40'(inv_alpha) * 40'(prev_sm);
                        state_in   = S_SUM;
                     end
                  end
               end
               default: ;
            endcase
         end

         S_MEAN: begin
            shown_in = mean_prod[DIV_SHIFT+PRESS_W-1:DIV_SHIFT];
            state_in = S_DONE;
         end

         // Record the entry and update the extremes
         S_SUM: begin
            mem_we       = 1'b1;
            wp_in        = (wp_ff == LAST_SLOT) ? '0 : wp_ff + 1'b1;
            last_sm_in   = sm_new;
            last_raw_in  = item_ff.sample;
            skip_left_in = cfg.skip_count;
            if (item_ff.sample > max_ff) max_in = item_ff.sample;
            if (item_ff.sample < min_ff) min_in = item_ff.sample;
            if (held_ff == FULL_COUNT) begin
               scan_addr_in = '0;
               scan_pend_in = 1'b0;
               scan_max_in  = '0;
               state_in     = S_SCAN;
            end else begin
               held_in  = held_ff + 1'b1;
               if (item_ff.sample > mwin_ff) mwin_in = item_ff.sample;
               state_in = S_DONE;
            end
         end

         // Rescan the full ring for the window maximum
         S_SCAN: begin
            rd_en        = 1'b1;
            rd_addr      = scan_addr_ff;
            scan_pend_in = 1'b1;
            if (scan_pend_ff && raw_q_ff > scan_max_ff) scan_max_in = raw_q_ff;
            if (scan_addr_ff == LAST_SLOT) begin
               state_in = S_SCAN_LAST;
            end else begin
               scan_addr_in = scan_addr_ff + 1'b1;
            end
         end

         S_SCAN_LAST: begin
            mwin_in  = (raw_q_ff > scan_max_ff) ? raw_q_ff : scan_max_ff;
            state_in = S_DONE;
         end

         // Hold until the response register is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_in.current_pressure = shown_ff;
               rsp_in.current_valid    = shown_valid_ff;
               rsp_in.running          = running_ff;
               rsp_in.filled_count     = held_ext[COUNT_W-1:0];
               rsp_in.window_max       = mwin_ff;
               rsp_in.overall_max      = max_ff;
               rsp_in.overall_min      = min_ff;
               rsp_in.newest_smoothed  = last_sm_ff;
               if (item_ff.kind == KIND_READ && rd_ok_ff) begin
                  rsp_in.read_raw      = raw_q_ff;
                  rsp_in.read_smoothed = smooth_q_ff;
                  rsp_in.read_valid    = 1'b1;
               end else begin
                  rsp_in.read_raw      = '0;
                  rsp_in.read_smoothed = '0;
                  rsp_in.read_valid    = 1'b0;
               end
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         wp_ff          <= '0;
         held_ff        <= '0;
         warm_cnt_ff    <= '0;
         warm_sum_ff    <= '0;
         skip_left_ff   <= '0;
         shown_ff       <= '0;
         shown_valid_ff <= 1'b1;
         running_ff     <= 1'b0;
         mwin_ff        <= '0;
         max_ff         <= '0;
         min_ff         <= MIN_START;
         last_sm_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         wp_ff          <= wp_in;
         held_ff        <= held_in;
         warm_cnt_ff    <= warm_cnt_in;
         warm_sum_ff    <= warm_sum_in;
         skip_left_ff   <= skip_left_in;
         shown_ff       <= shown_in;
         shown_valid_ff <= shown_valid_in;
         running_ff     <= running_in;
         mwin_ff        <= mwin_in;
         max_ff         <= max_in;
         min_ff         <= min_in;
         last_sm_ff     <= last_sm_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      last_raw_ff  <= last_raw_in;
      prod_a_ff    <= prod_a_in;
      prod_b_ff    <= prod_b_in;
      rd_ok_ff     <= rd_ok_in;
      scan_addr_ff <= scan_addr_in;
      scan_pend_ff <= scan_pend_in;
      scan_max_ff  <= scan_max_in;
      rsp_ff       <= rsp_in;
   end

   // Ring write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         raw_mem[wp_ff]    <= item_ff.sample;
         smooth_mem[wp_ff] <= sm_new;
      end
      if (rd_en) begin
         raw_q_ff    <= raw_mem[rd_addr];
         smooth_q_ff <= smooth_mem[rd_addr];
      end
   end

   // Checks
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= FULL_COUNT)
      else $error("held count beyond ring depth");

   a_wp_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      held_ff < FULL_COUNT |-> HC_W'(wp_ff) == held_ff)
      else $error("write pointer out of step with fill count");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      held_ff != '0 |-> min_ff <= max_ff)
      else $error("overall minimum above overall maximum");

   a_running_after_warmup: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> warm_cnt_ff == 3'(WARMUP_SAMPLES))
      else $error("recording started before warmup finished");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == S_EXEC)
      else $error("dequeued transaction not executed");

endmodule

[hw/rtl/pressure_history_recorder.sv]
// Top level of the pressure history recorder: csr registers, front end and
// back end. Depends on phr_pkg, phr_front and phr_back.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_data  (phr_req_type)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_data  (phr_rsp_type)
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// Back end paths: ignored samples, timeouts, skips, reads and warmup samples
// other than the last go from S_EXEC to S_DONE; the sample completing warmup
// passes S_MEAN; a record passes S_SUM and, into a full ring, also S_SCAN over
// every slot and S_SCAN_LAST, as the window maximum is rescanned through the
// single ring read port. A two-entry queue and the response register let
// requests be taken while a response waits. Reset is synchronous; the ring
// contents are left as they are. csr writes are always taken.
`timescale 1ns / 1ps

module pressure_history_recorder
   import phr_pkg::*;
#(
   parameter int HISTORY_DEPTH  = DEF_HISTORY_DEPTH,
   parameter int WARMUP_SAMPLES = DEF_WARMUP_SAMPLES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  phr_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output phr_rsp_type           rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   phr_cfg_type  cfg_ff, cfg_in;
   logic         q_valid;
   logic         q_pop;
   phr_item_type q_item;

   assign csr_ready = 1'b1;

   // Decode csr writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LOW_LIMIT:  cfg_in.low_limit  = csr_data[PRESS_W-1:0];
            CSR_HIGH_LIMIT: cfg_in.high_limit = csr_data[PRESS_W-1:0];
            CSR_ALPHA:      cfg_in.alpha      = csr_data[ALPHA_W-1:0];
            CSR_SKIP_COUNT: cfg_in.skip_count = csr_data[SKIP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_limit  <= LOW_LIMIT_RST;
         cfg_ff.high_limit <= HIGH_LIMIT_RST;
         cfg_ff.alpha      <= ALPHA_RST;
         cfg_ff.skip_count <= SKIP_COUNT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   phr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   phr_back #(
      .HISTORY_DEPTH  (HISTORY_DEPTH),
      .WARMUP_SAMPLES (WARMUP_SAMPLES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
